FILE: src/srint_pkg.sv
// shared types and widths for the segment / ray intersection unit
// no dependencies
package srint_pkg;

  localparam int CoordW = 32;   // Q16.16 coordinate
  localparam int DiffW  = 33;   // difference of two coordinates
  localparam int ProdW  = 66;   // product of two differences
  localparam int WideW  = 67;   // den and the two numerators
  localparam int LoW    = 34;   // low slice of a split wide operand
  localparam int HiW    = WideW - LoW;
  localparam int NumW   = 101;  // signed coordinate numerator
  localparam int RemW   = 100;  // magnitude / remainder in the divider
  localparam int QuoW   = 33;   // quotient bits resolved by the cell chain

  // request moving down the divider chain
  typedef struct packed {
    logic                hit;
    logic [WideW-1:0]    den;
    logic [RemW-1:0]     rem_x;
    logic [RemW-1:0]     rem_y;
    logic [QuoW-1:0]     q_x;
    logic [QuoW-1:0]     q_y;
    logic                neg_x;
    logic                neg_y;
    logic                ovf_x;
    logic                ovf_y;
  } div_t;

endpackage

FILE: src/srint_front.sv
// front pipeline: differences, cross products, range tests and coordinate numerators
// depends on srint_pkg
module srint_front import srint_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_req,
  input  logic                     action,
  input  logic signed [CoordW-1:0] self_start_x,
  input  logic signed [CoordW-1:0] self_start_y,
  input  logic signed [CoordW-1:0] self_end_x,
  input  logic signed [CoordW-1:0] self_end_y,
  input  logic signed [CoordW-1:0] other_start_x,
  input  logic signed [CoordW-1:0] other_start_y,
  input  logic signed [CoordW-1:0] other_end_x,
  input  logic signed [CoordW-1:0] other_end_y,
  input  logic                     limit_self,
  input  logic                     limit_other,
  output logic                     div_valid,
  output div_t                     div_out
);

  logic [8:0] v_r;

  // stage 1: directions and start offsets
  logic signed [CoordW-1:0] s1_ax_r, s1_ay_r;
  logic signed [DiffW-1:0]  s1_bx_r, s1_by_r, s1_dx_r, s1_dy_r;
  logic signed [DiffW-1:0]  s1_ecy_r, s1_eax_r, s1_eay_r;
  logic                     s1_act_r, s1_ls_r, s1_lo_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_ax_r  <= self_start_x;
      s1_ay_r  <= self_start_y;
      s1_bx_r  <= DiffW'(self_end_x) - DiffW'(self_start_x);
      s1_by_r  <= DiffW'(self_end_y) - DiffW'(self_start_y);
      s1_dx_r  <= DiffW'(other_end_x) - DiffW'(other_start_x);
      s1_dy_r  <= DiffW'(other_end_y) - DiffW'(other_start_y);
      s1_ecy_r <= DiffW'(other_start_y) - DiffW'(self_start_y);
      s1_eax_r <= DiffW'(self_start_x) - DiffW'(other_start_x);
      s1_eay_r <= DiffW'(self_start_y) - DiffW'(other_start_y);
      s1_act_r <= action;
      s1_ls_r  <= limit_self;
      s1_lo_r  <= limit_other;
    end
  end

  // stage 2: six cross-product terms
  logic signed [ProdW-1:0]  s2_dxby_r, s2_bxdy_r, s2_dxe_r, s2_dye_r, s2_eby_r, s2_ebx_r;
  logic signed [CoordW-1:0] s2_ax_r, s2_ay_r;
  logic signed [DiffW-1:0]  s2_bx_r, s2_by_r;
  logic                     s2_act_r, s2_ls_r, s2_lo_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_dxby_r <= s1_dx_r * s1_by_r;
      s2_bxdy_r <= s1_bx_r * s1_dy_r;
      s2_dxe_r  <= s1_dx_r * s1_ecy_r;
      s2_dye_r  <= s1_dy_r * s1_eax_r;
      s2_eby_r  <= s1_eax_r * s1_by_r;
      s2_ebx_r  <= s1_eay_r * s1_bx_r;
      s2_ax_r   <= s1_ax_r;
      s2_ay_r   <= s1_ay_r;
      s2_bx_r   <= s1_bx_r;
      s2_by_r   <= s1_by_r;
      s2_act_r  <= s1_act_r;
      s2_ls_r   <= s1_ls_r;
      s2_lo_r   <= s1_lo_r;
    end
  end

  // stage 3: denominator and numerators
  logic signed [WideW-1:0]  s3_den_r, s3_nla_r, s3_nmu_r;
  logic signed [CoordW-1:0] s3_ax_r, s3_ay_r;
  logic signed [DiffW-1:0]  s3_bx_r, s3_by_r;
  logic                     s3_act_r, s3_ls_r, s3_lo_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s3_den_r <= WideW'(s2_dxby_r) - WideW'(s2_bxdy_r);
      s3_nla_r <= WideW'(s2_dxe_r) + WideW'(s2_dye_r);
      s3_nmu_r <= WideW'(s2_eby_r) - WideW'(s2_ebx_r);
      s3_ax_r  <= s2_ax_r;
      s3_ay_r  <= s2_ay_r;
      s3_bx_r  <= s2_bx_r;
      s3_by_r  <= s2_by_r;
      s3_act_r <= s2_act_r;
      s3_ls_r  <= s2_ls_r;
      s3_lo_r  <= s2_lo_r;
    end
  end

  // stage 4: make the denominator positive
  logic signed [WideW-1:0]  s4_den_r, s4_nla_r, s4_nmu_r;
  logic signed [CoordW-1:0] s4_ax_r, s4_ay_r;
  logic signed [DiffW-1:0]  s4_bx_r, s4_by_r;
  logic                     s4_nz_r, s4_act_r, s4_ls_r, s4_lo_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s4_den_r <= s3_den_r[WideW-1] ? -s3_den_r : s3_den_r;
      s4_nla_r <= s3_den_r[WideW-1] ? -s3_nla_r : s3_nla_r;
      s4_nmu_r <= s3_den_r[WideW-1] ? -s3_nmu_r : s3_nmu_r;
      s4_nz_r  <= (s3_den_r != '0);
      s4_ax_r  <= s3_ax_r;
      s4_ay_r  <= s3_ay_r;
      s4_bx_r  <= s3_bx_r;
      s4_by_r  <= s3_by_r;
      s4_act_r <= s3_act_r;
      s4_ls_r  <= s3_ls_r;
      s4_lo_r  <= s3_lo_r;
    end
  end

  // stage 5: range tests and split partial products
  logic la_unit, mu_unit, ok;
  always_comb begin
    la_unit = !s4_nla_r[WideW-1] && (s4_nla_r <= s4_den_r);
    mu_unit = !s4_nmu_r[WideW-1] && (s4_nmu_r <= s4_den_r);
    if (s4_act_r) begin
      ok = !s4_nla_r[WideW-1] && mu_unit;
    end else begin
      ok = (!s4_ls_r || la_unit) && (!s4_lo_r || mu_unit);
    end
  end

  logic signed [WideW-1:0]   s5_pdl_x_r, s5_pdl_y_r;
  logic signed [ProdW-1:0]   s5_pdh_x_r, s5_pdh_y_r;
  logic signed [WideW:0]     s5_pnl_x_r, s5_pnl_y_r;
  logic signed [ProdW-1:0]   s5_pnh_x_r, s5_pnh_y_r;
  logic [WideW-1:0]          s5_den_r;
  logic                      s5_hit_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s5_pdl_x_r <= s4_ax_r * $signed({1'b0, s4_den_r[LoW-1:0]});
      s5_pdl_y_r <= s4_ay_r * $signed({1'b0, s4_den_r[LoW-1:0]});
      s5_pdh_x_r <= s4_ax_r * $signed({1'b0, s4_den_r[WideW-1:LoW]});
      s5_pdh_y_r <= s4_ay_r * $signed({1'b0, s4_den_r[WideW-1:LoW]});
      s5_pnl_x_r <= s4_bx_r * $signed({1'b0, s4_nla_r[LoW-1:0]});
      s5_pnl_y_r <= s4_by_r * $signed({1'b0, s4_nla_r[LoW-1:0]});
      s5_pnh_x_r <= s4_bx_r * $signed(s4_nla_r[WideW-1:LoW]);
      s5_pnh_y_r <= s4_by_r * $signed(s4_nla_r[WideW-1:LoW]);
      s5_den_r   <= s4_den_r;
      s5_hit_r   <= s4_nz_r && ok;
    end
  end

  // stage 6: recombine split products
  logic signed [NumW-1:0] s6_tx_r, s6_ty_r, s6_ux_r, s6_uy_r;
  logic [WideW-1:0]       s6_den_r;
  logic                   s6_hit_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s6_tx_r  <= (NumW'(s5_pdh_x_r) <<< LoW) + NumW'(s5_pdl_x_r);
      s6_ty_r  <= (NumW'(s5_pdh_y_r) <<< LoW) + NumW'(s5_pdl_y_r);
      s6_ux_r  <= (NumW'(s5_pnh_x_r) <<< LoW) + NumW'(s5_pnl_x_r);
      s6_uy_r  <= (NumW'(s5_pnh_y_r) <<< LoW) + NumW'(s5_pnl_y_r);
      s6_den_r <= s5_den_r;
      s6_hit_r <= s5_hit_r;
    end
  end

  // stage 7: coordinate numerators a*den + nla*b
  logic signed [NumW-1:0] s7_nx_r, s7_ny_r;
  logic [WideW-1:0]       s7_den_r;
  logic                   s7_hit_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s7_nx_r  <= s6_tx_r + s6_ux_r;
      s7_ny_r  <= s6_ty_r + s6_uy_r;
      s7_den_r <= s6_den_r;
      s7_hit_r <= s6_hit_r;
    end
  end

  // stage 8: magnitudes
  logic signed [NumW-1:0] neg_nx, neg_ny;
  assign neg_nx = -s7_nx_r;
  assign neg_ny = -s7_ny_r;

  logic [RemW-1:0]  s8_mx_r, s8_my_r;
  logic             s8_negx_r, s8_negy_r, s8_hit_r;
  logic [WideW-1:0] s8_den_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s8_negx_r <= s7_nx_r[NumW-1];
      s8_negy_r <= s7_ny_r[NumW-1];
      s8_mx_r   <= s7_nx_r[NumW-1] ? neg_nx[RemW-1:0] : s7_nx_r[RemW-1:0];
      s8_my_r   <= s7_ny_r[NumW-1] ? neg_ny[RemW-1:0] : s7_ny_r[RemW-1:0];
      s8_den_r  <= s7_den_r;
      s8_hit_r  <= s7_hit_r;
    end
  end

  // stage 9: quotient overflow check, launch into divider chain
  logic [RemW-1:0] den_top;
  assign den_top = RemW'(s8_den_r) << QuoW;

  always_ff @(posedge clk) begin
    if (en) begin
      div_out.hit   <= s8_hit_r;
      div_out.den   <= s8_den_r;
      div_out.rem_x <= s8_mx_r;
      div_out.rem_y <= s8_my_r;
      div_out.q_x   <= '0;
      div_out.q_y   <= '0;
      div_out.neg_x <= s8_negx_r;
      div_out.neg_y <= s8_negy_r;
      div_out.ovf_x <= (s8_mx_r >= den_top);
      div_out.ovf_y <= (s8_my_r >= den_top);
    end
  end

  // request valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[7:0], in_req};
    end
  end

  assign div_valid = v_r[8];

endmodule

FILE: src/srint_div_cell.sv
// one restoring-division cell: resolves one quotient bit for both coordinates
// depends on srint_pkg
module srint_div_cell import srint_pkg::*; #(
  parameter int SHIFT = 0
) (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  logic in_v,
  input  div_t in_d,
  output logic out_v,
  output div_t out_d
);

  logic [RemW-1:0] dsh;
  logic            ge_x, ge_y;
  div_t            d_nxt;

  // compare and subtract shifted denominator
  always_comb begin
    dsh   = RemW'(in_d.den) << SHIFT;
    ge_x  = (in_d.rem_x >= dsh);
    ge_y  = (in_d.rem_y >= dsh);
    d_nxt = in_d;
    if (ge_x) begin
      d_nxt.rem_x = in_d.rem_x - dsh;
    end
    if (ge_y) begin
      d_nxt.rem_y = in_d.rem_y - dsh;
    end
    d_nxt.q_x[SHIFT] = ge_x;
    d_nxt.q_y[SHIFT] = ge_y;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_d <= d_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v <= 1'b0;
    end else if (en) begin
      out_v <= in_v;
    end
  end

endmodule

FILE: src/segment_ray_intersection_unit.sv
// top level of the segment / ray intersection unit
// depends on srint_pkg, srint_front, srint_div_cell
//
// Usage: one request carries a self segment and an other segment in signed
// Q16.16 plus a mode (segment test with limit flags, or ray cast). Each
// request yields exactly one result: hit flag and the hit point, truncated
// toward zero and saturated to Q16.16, or zeros when there is no hit.
// Both channels are valid/ready. A request is taken every cycle while the
// output side keeps up; throughput is one request per cycle.
// From acceptance to out_valid a request passes nine arithmetic stages
// (products, sign fix-up, split 34-bit partial products, magnitude), a row
// of 33 divider cells, one quotient bit per cell, and the output register.
// The output has a one-entry skid stage: when the receiver stalls, one more
// result is parked and then the whole pipeline holds, with in_ready low
// until the skid entry drains.
// Reset clears all valid bits; no results are pending afterwards.
module segment_ray_intersection_unit import srint_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_action,
  input  logic signed [CoordW-1:0] in_self_start_x,
  input  logic signed [CoordW-1:0] in_self_start_y,
  input  logic signed [CoordW-1:0] in_self_end_x,
  input  logic signed [CoordW-1:0] in_self_end_y,
  input  logic signed [CoordW-1:0] in_other_start_x,
  input  logic signed [CoordW-1:0] in_other_start_y,
  input  logic signed [CoordW-1:0] in_other_end_x,
  input  logic signed [CoordW-1:0] in_other_end_y,
  input  logic                     in_limit_self,
  input  logic                     in_limit_other,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_hit,
  output logic signed [CoordW-1:0] out_point_x,
  output logic signed [CoordW-1:0] out_point_y
);

  logic adv;
  logic skid_v_r;

  assign adv      = !skid_v_r;
  assign in_ready = adv;

  div_t chain_d [QuoW+1];
  logic chain_v [QuoW+1];

  // arithmetic front end
  srint_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (adv),
    .in_req        (in_valid && adv),
    .action        (in_action),
    .self_start_x  (in_self_start_x),
    .self_start_y  (in_self_start_y),
    .self_end_x    (in_self_end_x),
    .self_end_y    (in_self_end_y),
    .other_start_x (in_other_start_x),
    .other_start_y (in_other_start_y),
    .other_end_x   (in_other_end_x),
    .other_end_y   (in_other_end_y),
    .limit_self    (in_limit_self),
    .limit_other   (in_limit_other),
    .div_valid     (chain_v[0]),
    .div_out       (chain_d[0])
  );

  // divider row, most significant quotient bit first
  for (genvar i = 0; i < QuoW; i++) begin : g_cell
    srint_div_cell #(.SHIFT(QuoW - 1 - i)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (adv),
      .in_v  (chain_v[i]),
      .in_d  (chain_d[i]),
      .out_v (chain_v[i+1]),
      .out_d (chain_d[i+1])
    );
  end

  // saturate quotients and apply sign
  div_t fin;
  logic res_hit;
  logic [CoordW-1:0] res_x, res_y;
  logic [QuoW-1:0] nq_x, nq_y;

  assign fin  = chain_d[QuoW];
  assign nq_x = -fin.q_x;
  assign nq_y = -fin.q_y;

  always_comb begin
    res_hit = fin.hit;
    if (fin.neg_x) begin
      res_x = (fin.ovf_x || fin.q_x > QuoW'(33'h080000000)) ? 32'h80000000 : nq_x[CoordW-1:0];
    end else begin
      res_x = (fin.ovf_x || fin.q_x > QuoW'(33'h07fffffff)) ? 32'h7fffffff : fin.q_x[CoordW-1:0];
    end
    if (fin.neg_y) begin
      res_y = (fin.ovf_y || fin.q_y > QuoW'(33'h080000000)) ? 32'h80000000 : nq_y[CoordW-1:0];
    end else begin
      res_y = (fin.ovf_y || fin.q_y > QuoW'(33'h07fffffff)) ? 32'h7fffffff : fin.q_y[CoordW-1:0];
    end
    if (!fin.hit) begin
      res_x = '0;
      res_y = '0;
    end
  end

  // output register with skid entry
  logic              out_valid_r, out_hit_r, skid_hit_r;
  logic [CoordW-1:0] out_x_r, out_y_r, skid_x_r, skid_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_v_r    <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      if (skid_v_r) begin
        out_valid_r <= 1'b1;
        skid_v_r    <= 1'b0;
      end else begin
        out_valid_r <= chain_v[QuoW];
      end
    end else if (chain_v[QuoW] && adv) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_ready) begin
      if (skid_v_r) begin
        out_hit_r <= skid_hit_r;
        out_x_r   <= skid_x_r;
        out_y_r   <= skid_y_r;
      end else begin
        out_hit_r <= res_hit;
        out_x_r   <= res_x;
        out_y_r   <= res_y;
      end
    end else if (chain_v[QuoW] && adv) begin
      skid_hit_r <= res_hit;
      skid_x_r   <= res_x;
      skid_y_r   <= res_y;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_hit     = out_hit_r;
  assign out_point_x = out_x_r;
  assign out_point_y = out_y_r;

`ifndef ASSERT_OFF
  // skid entry is only used behind a full output register
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_valid_r)
    else $error("skid entry valid while output register empty");

  // a miss always reports the origin
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_hit_r) |-> (out_x_r == '0 && out_y_r == '0))
    else $error("miss with nonzero point");

  // skid drains only when the receiver takes a result
  a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(skid_v_r) |-> $past(out_ready))
    else $error("skid entry dropped without a transfer");
`endif

endmodule

FILE: bench/tb.sv
// testbench for segment_ray_intersection_unit: random and directed segment/ray requests
// predicts hit and point exactly with wide signed integers; depends on srint_pkg and the rtl
`timescale 1ns / 1ps

module tb;
  import srint_pkg::*;

  localparam int NumRandom = 1000;

  typedef struct {
    logic        action;
    logic signed [CoordW-1:0] sx0, sy0, sx1, sy1, ox0, oy0, ox1, oy1;
    logic        lim_self, lim_other;
  } seg_req_t;

  typedef struct {
    logic        hit;
    logic signed [CoordW-1:0] px, py;
  } hit_res_t;

  // scoreboard for intersection results
  class hit_scoreboard;
    hit_res_t pending[$];
    int errors = 0;
    int checked = 0;
    int hits = 0;

    // truncated, saturated coordinate of base + num/den * dir
    function automatic logic signed [CoordW-1:0] hit_coord(
        logic signed [199:0] base, logic signed [199:0] dir,
        logic signed [199:0] den, logic signed [199:0] num);
      logic signed [199:0] n, q;
      n = base * den + num * dir;
      q = n / den;
      if (q > 200'sd2147483647) return 32'sh7fffffff;
      if (q < -200'sd2147483648) return 32'sh80000000;
      return q[CoordW-1:0];
    endfunction

    function automatic bit in_unit(logic signed [199:0] num, logic signed [199:0] den);
      return num >= 0 && num <= den;
    endfunction

    // note an accepted request and queue its expected result
    function void note_request(seg_req_t r);
      logic signed [199:0] ax, ay, bx, by, cx, cy, dx, dy, den, nla, nmu;
      hit_res_t e;
      bit ok;
      ax = r.sx0; ay = r.sy0; bx = r.sx1 - ax; by = r.sy1 - ay;
      cx = r.ox0; cy = r.oy0; dx = r.ox1 - cx; dy = r.oy1 - cy;
      e = '{1'b0, '0, '0};
      den = dx * by - bx * dy;
      if (den != 0) begin
        nla = dx * (cy - ay) + dy * (ax - cx);
        nmu = (ax - cx) * by - (ay - cy) * bx;
        if (den < 0) begin
          den = -den; nla = -nla; nmu = -nmu;
        end
        if (r.action) ok = nla >= 0 && in_unit(nmu, den);
        else ok = (!r.lim_self || in_unit(nla, den)) && (!r.lim_other || in_unit(nmu, den));
        if (ok) begin
          e.hit = 1'b1;
          e.px = hit_coord(ax, bx, den, nla);
          e.py = hit_coord(ay, by, den, nla);
        end
      end
      pending.push_back(e);
    endfunction

    // compare one result with the oldest expectation
    function void check_result(hit_res_t a);
      hit_res_t e;
      if (pending.size() == 0) begin
        $display("%0t unexpected result hit=%0d x=%h y=%h", $time, a.hit, a.px, a.py);
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (a.hit) hits++;
      if (a.hit !== e.hit) begin
        $display("%0t hit mismatch: expected %0d actual %0d", $time, e.hit, a.hit);
        errors++;
      end
      if (a.px !== e.px) begin
        $display("%0t point_x mismatch: expected %h actual %h", $time, e.px, a.px);
        errors++;
      end
      if (a.py !== e.py) begin
        $display("%0t point_y mismatch: expected %h actual %h", $time, e.py, a.py);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_hit;
  logic signed [CoordW-1:0] out_point_x, out_point_y;
  seg_req_t req = '{1'b0, '0, '0, '0, '0, '0, '0, '0, '0, 1'b0, 1'b0};
  hit_scoreboard sb = new();
  bit sending_done = 0;
  bit long_stall = 0;
  int directed_cnt = 0;

  always #5 clk = ~clk;

  segment_ray_intersection_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_action(req.action),
    .in_self_start_x(req.sx0), .in_self_start_y(req.sy0),
    .in_self_end_x(req.sx1), .in_self_end_y(req.sy1),
    .in_other_start_x(req.ox0), .in_other_start_y(req.oy0),
    .in_other_end_x(req.ox1), .in_other_end_y(req.oy1),
    .in_limit_self(req.lim_self), .in_limit_other(req.lim_other),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_hit(out_hit), .out_point_x(out_point_x), .out_point_y(out_point_y)
  );

  // note accepted requests and check accepted results at the rising edge
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.note_request(req);
    if (rst_n && out_valid && out_ready)
      sb.check_result('{out_hit, out_point_x, out_point_y});
  end

  // offer one request with a random gap, hold it until accepted
  task automatic send_request(seg_req_t r);
    int gap;
    gap = $urandom_range(0, 5);
    if ($urandom_range(0, 3) == 0) gap = 0;
    repeat (gap) @(negedge clk);
    req = r;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  function automatic logic signed [CoordW-1:0] rand_coord(int kind);
    case (kind)
      0: return $urandom();
      1: return $signed($urandom_range(0, 40)) - 20 <<< 16;
      2: return ($urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000);
      default: return $signed($urandom_range(0, 32'h000fffff)) - 32'sh00080000;
    endcase
  endfunction

  function automatic seg_req_t rand_request();
    seg_req_t r;
    int kind;
    kind = $urandom_range(0, 9);
    kind = (kind < 2) ? 0 : (kind < 6) ? 1 : (kind < 7) ? 2 : 3;
    r.action = 1'($urandom_range(0, 1));
    r.sx0 = rand_coord(kind); r.sy0 = rand_coord(kind);
    r.sx1 = rand_coord(kind); r.sy1 = rand_coord(kind);
    r.ox0 = rand_coord(kind); r.oy0 = rand_coord(kind);
    r.ox1 = rand_coord(kind); r.oy1 = rand_coord(kind);
    // occasionally make the segments parallel
    if ($urandom_range(0, 15) == 0) begin
      r.ox1 = r.ox0 + (r.sx1 - r.sx0);
      r.oy1 = r.oy0 + (r.sy1 - r.sy0);
    end
    r.lim_self = 1'($urandom_range(0, 1));
    r.lim_other = 1'($urandom_range(0, 1));
    return r;
  endfunction

  function automatic seg_req_t mk(int act, int a, int b, int c, int d,
                                  int e, int f, int g, int h, int ls, int lo);
    seg_req_t r;
    r = '{act[0], a, b, c, d, e, f, g, h, ls[0], lo[0]};
    return r;
  endfunction

  // receiver: random stalls, one long hold-off early in the random phase
  initial begin
    int wait_cyc;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (long_stall) begin
        out_ready = 1'b0;
        repeat (150) @(negedge clk);
        long_stall = 0;
      end
      wait_cyc = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 5);
      out_ready = 1'b0;
      repeat (wait_cyc) @(negedge clk);
      out_ready = 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // stimulus
  initial begin
    localparam int One = 32'h10000;
    seg_req_t dir_list[$];
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    // crossing segments, both limits, in segment and ray mode
    dir_list.push_back(mk(0, 0, 0, 2*One, 2*One, 0, 2*One, 2*One, 0, 1, 1));
    dir_list.push_back(mk(1, 0, 0, 2*One, 2*One, 0, 2*One, 2*One, 0, 1, 1));
    // intersection beyond self end: limit on vs off, ray hits
    dir_list.push_back(mk(0, 0, 0, One, 0, 3*One, -One, 3*One, One, 1, 1));
    dir_list.push_back(mk(0, 0, 0, One, 0, 3*One, -One, 3*One, One, 0, 1));
    dir_list.push_back(mk(1, 0, 0, One, 0, 3*One, -One, 3*One, One, 0, 0));
    // behind the ray start
    dir_list.push_back(mk(1, 0, 0, One, 0, -3*One, -One, -3*One, One, 0, 0));
    dir_list.push_back(mk(0, 0, 0, One, 0, -3*One, -One, -3*One, One, 0, 0));
    // parallel and degenerate
    dir_list.push_back(mk(0, 0, 0, One, One, One, 0, 2*One, One, 0, 0));
    dir_list.push_back(mk(1, 5, 5, 5, 5, 0, 0, One, One, 0, 0));
    // endpoint touching: la = 1, mu = 0
    dir_list.push_back(mk(0, 0, 0, One, 0, One, 0, One, One, 1, 1));
    // other parameter outside unit range
    dir_list.push_back(mk(0, 0, 0, One, One, 0, 3*One, One, 2*One, 0, 1));
    dir_list.push_back(mk(0, 0, 0, One, One, 0, 3*One, One, 2*One, 0, 0));
    // saturation of the hit point, both signs
    dir_list.push_back(mk(0, 0, 0, 1, 1, 32'h7fffffff, 32'h80000000,
                          32'h7fffffff, 32'h7fffffff, 0, 0));
    dir_list.push_back(mk(0, 0, 0, -1, -1, 32'h80000000, 32'h80000000,
                          32'h80000000, 32'h7fffffff, 0, 0));
    // extreme coordinates everywhere
    dir_list.push_back(mk(0, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
                          32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 1, 1));
    dir_list.push_back(mk(1, 32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff,
                          32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000, 1, 0));
    // negative truncation toward zero
    dir_list.push_back(mk(0, 0, 0, -3, -1, -1, 0, -1, -5, 0, 0));
    directed_cnt = dir_list.size();
    foreach (dir_list[i]) send_request(dir_list[i]);
    long_stall = 1;
    for (int i = 0; i < NumRandom; i++) send_request(rand_request());
    sending_done = 1;
  end

  // end of run
  initial begin
    int drain;
    wait (sending_done);
    drain = 0;
    while (sb.pending.size() != 0 && drain < 20000) begin
      @(posedge clk);
      drain++;
    end
    repeat (60) @(posedge clk);
    if (sb.pending.size() != 0) begin
      $display("%0t %0d expected results never arrived", $time, sb.pending.size());
      sb.errors++;
    end
    $display("covered %0d directed and %0d random requests, %0d results checked, %0d hits",
             directed_cnt, NumRandom, sb.checked, sb.hits);
    if (sb.errors == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("tb: FAIL");
    $finish;
  end

endmodule
